// ===== design/joystick_axis_conditioner_macros.svh =====
// Assertion macros shared by the joystick axis conditioner RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define JAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Expression must never be true outside reset.
`define JAC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define JAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define JAC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/jac_pkg.sv =====
// Shared types, constants and the control-store program of the axis conditioner.
// Used by jac_sequencer, jac_datapath and joystick_axis_conditioner.
package jac_pkg;

  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned DEADZONE_W   = 11;
  localparam int unsigned WEIGHT_W     = 9;
  localparam int unsigned WEIGHT_SHIFT = 8;
  localparam int unsigned MUL_A_W      = 16;
  localparam int unsigned OUT_W        = 16;

  localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE     = 9'd256;
  localparam logic [WEIGHT_W-1:0]   RESET_WEIGHT   = 9'd51;
  localparam logic [DEADZONE_W-1:0] RESET_DEADZONE = 11'd50;
  localparam logic [MUL_A_W-1:0]    SCALE_NEG      = 16'd32768;
  localparam logic [MUL_A_W-1:0]    SCALE_POS      = 16'd32767;
  localparam logic [MUL_A_W-1:0]    SCALE_THR      = 16'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_MIN         = 3'd0,
    CFG_AXIS_CENTER      = 3'd1,
    CFG_AXIS_MAX         = 3'd2,
    CFG_DEADZONE         = 3'd3,
    CFG_THROTTLE_MODE    = 3'd4,
    CFG_SMOOTHING_WEIGHT = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_MUL_NEW,
    OP_MUL_OLD,
    OP_AVG,
    OP_CLAMP,
    OP_DIFF,
    OP_RANGE,
    OP_MUL_SCALE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SAT,
    OP_CLEAR,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ZERO,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [3:0] step_t;

  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_MUL_NEW   = 4'd1;
  localparam step_t S_MUL_OLD   = 4'd2;
  localparam step_t S_AVG       = 4'd3;
  localparam step_t S_CLAMP     = 4'd4;
  localparam step_t S_DIFF      = 4'd5;
  localparam step_t S_RANGE     = 4'd6;
  localparam step_t S_MUL_SCALE = 4'd7;
  localparam step_t S_DIV_INIT  = 4'd8;
  localparam step_t S_DIV       = 4'd9;
  localparam step_t S_SAT       = 4'd10;
  localparam step_t S_ZERO      = 4'd11;
  localparam step_t S_EMIT      = 4'd12;
  localparam step_t S_RET       = 4'd13;
  localparam step_t S_LAST      = S_RET;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic zero;
    logic div_more;
    logic out_busy;
  } status_t;

  // Control store: one word per step, jump taken when cond holds.
  function automatic ctrl_t jac_rom(input step_t step);
    ctrl_t word;
    word = '{op: OP_NOP, cond: COND_ALWAYS, target: S_WAIT};
    case (step)
      S_WAIT:      word = '{op: OP_WAIT_IN,   cond: COND_NO_INPUT, target: S_WAIT};
      S_MUL_NEW:   word = '{op: OP_MUL_NEW,   cond: COND_NEXT,     target: S_WAIT};
      S_MUL_OLD:   word = '{op: OP_MUL_OLD,   cond: COND_NEXT,     target: S_WAIT};
      S_AVG:       word = '{op: OP_AVG,       cond: COND_NEXT,     target: S_WAIT};
      S_CLAMP:     word = '{op: OP_CLAMP,     cond: COND_NEXT,     target: S_WAIT};
      S_DIFF:      word = '{op: OP_DIFF,      cond: COND_NEXT,     target: S_WAIT};
      S_RANGE:     word = '{op: OP_RANGE,     cond: COND_NEXT,     target: S_WAIT};
      S_MUL_SCALE: word = '{op: OP_MUL_SCALE, cond: COND_ZERO,     target: S_ZERO};
      S_DIV_INIT:  word = '{op: OP_DIV_INIT,  cond: COND_NEXT,     target: S_WAIT};
      S_DIV:       word = '{op: OP_DIV_STEP,  cond: COND_DIV_MORE, target: S_DIV};
      S_SAT:       word = '{op: OP_SAT,       cond: COND_ALWAYS,   target: S_EMIT};
      S_ZERO:      word = '{op: OP_CLEAR,     cond: COND_NEXT,     target: S_WAIT};
      S_EMIT:      word = '{op: OP_EMIT,      cond: COND_OUT_BUSY, target: S_EMIT};
      S_RET:       word = '{op: OP_NOP,       cond: COND_ALWAYS,   target: S_WAIT};
      default:     word = '{op: OP_NOP,       cond: COND_ALWAYS,   target: S_WAIT};
    endcase
    return word;
  endfunction

endpackage

// ===== design/jac_sequencer.sv =====
// Step counter and control-store lookup of the axis conditioner.
// Depends on jac_pkg and joystick_axis_conditioner_macros.svh.
`include "joystick_axis_conditioner_macros.svh"

module jac_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jac_pkg::status_t status_i,
  output jac_pkg::ctrl_t   ctrl_o
);
  import jac_pkg::*;

  step_t step_q, step_d;
  logic  jump;

  assign ctrl_o = jac_rom(step_q);

  always_comb begin
    case (ctrl_o.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !status_i.in_valid;
      COND_ZERO:     jump = status_i.zero;
      COND_DIV_MORE: jump = status_i.div_more;
      COND_OUT_BUSY: jump = status_i.out_busy;
      default:       jump = 1'b1;
    endcase
    step_d = jump ? ctrl_o.target : step_t'(step_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  `JAC_ASSERT_NEVER(a_step_in_program, clk_i, rst_ni, step_q > S_LAST, "step left program")

endmodule

// ===== design/jac_datapath.sv =====
// Datapath of the axis conditioner: average, clamp, deadzone, scale, divide.
// Driven by control words from jac_sequencer; depends on jac_pkg and the macros header.
`include "joystick_axis_conditioner_macros.svh"

module jac_datapath #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jac_pkg::ctrl_t                     ctrl_i,
  output jac_pkg::status_t                   status_o,
  input  logic                               in_valid_i,
  input  logic [SAMPLE_BITS-1:0]             raw_sample_i,
  input  logic [SAMPLE_BITS-1:0]             axis_min_i,
  input  logic [SAMPLE_BITS-1:0]             axis_center_i,
  input  logic [SAMPLE_BITS-1:0]             axis_max_i,
  input  logic [jac_pkg::DEADZONE_W-1:0]     deadzone_i,
  input  logic                               throttle_mode_i,
  input  logic [jac_pkg::WEIGHT_W-1:0]       smoothing_weight_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [jac_pkg::OUT_W-1:0]   axis_value_o
);
  import jac_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned LW    = SB + FB;
  localparam int unsigned PW    = MUL_A_W + LW;
  // Scaled distance is below 2^SB times the largest factor 2^(MUL_A_W-1).
  localparam int unsigned NUM_W = SB + MUL_A_W - 1;
  localparam int unsigned CW    = $clog2(NUM_W);
  localparam int unsigned DW    = ((SB > DEADZONE_W) ? SB : DEADZONE_W) + 2;

  logic [SB-1:0]        raw_q, v_q, mdz_q, range_q, rem_q;
  logic [LW-1:0]        level_q;
  logic                 seeded_q, out_valid_q;
  logic [PW-1:0]        prod_q, acc_q;
  logic signed [DW-1:0] dist_q;
  logic                 neg_q, zero_q;
  logic [MUL_A_W-1:0]   k_q;
  logic [NUM_W-1:0]     quo_q;
  logic [CW-1:0]        cnt_q;
  logic [OUT_W-1:0]     result_q, axis_value_q;

  logic                 accept;
  logic [WEIGHT_W-1:0]  w_eff, w_cmp;
  logic [MUL_A_W-1:0]   mul_a;
  logic [LW-1:0]        mul_b;
  logic [PW-1:0]        product;
  logic [PW:0]          avg_sum;
  logic [SB-1:0]        whole, clamped;
  logic signed [DW-1:0] v_s, c_s, lo_s, hi_s, dz_s, diff, dist_d, span, mdz;
  logic                 neg_d, below, zero_d;
  logic [MUL_A_W-1:0]   k_d, q_sat;
  logic [SB:0]          rem_shift;
  logic                 fits;
  logic [SB:0]          rem_sub;
  logic                 q_big;

  assign accept = (ctrl_i.op == OP_WAIT_IN) && in_valid_i;

  // EMA weights, new sample weight capped at one
  assign w_eff = (smoothing_weight_i > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight_i;
  assign w_cmp = WEIGHT_ONE - w_eff;

  always_comb begin
    case (ctrl_i.op)
      OP_MUL_NEW: begin
        mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, w_eff};
        mul_b = {raw_q, {FB{1'b0}}};
      end
      OP_MUL_OLD: begin
        mul_a = {{(MUL_A_W-WEIGHT_W){1'b0}}, w_cmp};
        mul_b = level_q;
      end
      default: begin
        mul_a = k_q;
        mul_b = {{FB{1'b0}}, mdz_q};
      end
    endcase
  end

  assign product = {{LW{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  assign avg_sum = {1'b0, acc_q} + {1'b0, prod_q};

  assign whole   = level_q[LW-1:FB];
  assign clamped = (whole < axis_min_i) ? axis_min_i :
                   ((whole > axis_max_i) ? axis_max_i : whole);

  assign v_s  = $signed({{(DW-SB){1'b0}}, v_q});
  assign c_s  = $signed({{(DW-SB){1'b0}}, axis_center_i});
  assign lo_s = $signed({{(DW-SB){1'b0}}, axis_min_i});
  assign hi_s = $signed({{(DW-SB){1'b0}}, axis_max_i});
  assign dz_s = $signed({{(DW-DEADZONE_W){1'b0}}, deadzone_i});

  assign diff   = v_s - c_s;
  assign neg_d  = !throttle_mode_i && (v_q < axis_center_i);
  assign dist_d = neg_d ? -diff : diff;

  // Active range on the side of centre the value lies on
  assign span   = neg_q ? (c_s - lo_s - dz_s) : (hi_s - c_s - dz_s);
  assign below  = throttle_mode_i ? (dist_q <= dz_s) : (dist_q < dz_s);
  assign zero_d = below || span[DW-1] || (span == '0);
  assign mdz    = dist_q - dz_s;
  assign k_d    = throttle_mode_i ? SCALE_THR : (neg_q ? SCALE_NEG : SCALE_POS);

  // Restoring division, one quotient bit per step
  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, range_q};
  assign rem_sub   = fits ? (rem_shift - {1'b0, range_q}) : rem_shift;

  assign q_big = quo_q > {{(NUM_W-MUL_A_W){1'b0}}, k_q};
  assign q_sat = q_big ? k_q : quo_q[MUL_A_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        seeded_q <= 1'b1;
      end
      if ((ctrl_i.op == OP_EMIT) && !(out_valid_q && out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_WAIT_IN: begin
        if (accept) begin
          raw_q <= raw_sample_i;
          if (!seeded_q) begin
            level_q <= throttle_mode_i ? {axis_min_i, {FB{1'b0}}}
                                       : {axis_center_i, {FB{1'b0}}};
          end
        end
      end
      OP_MUL_NEW: prod_q <= product;
      OP_MUL_OLD: begin
        acc_q  <= prod_q;
        prod_q <= product;
      end
      OP_AVG:   level_q <= avg_sum[LW+WEIGHT_SHIFT-1:WEIGHT_SHIFT];
      OP_CLAMP: v_q <= clamped;
      OP_DIFF: begin
        neg_q  <= neg_d;
        dist_q <= dist_d;
      end
      OP_RANGE: begin
        zero_q  <= zero_d;
        mdz_q   <= mdz[SB-1:0];
        range_q <= span[SB-1:0];
        k_q     <= k_d;
      end
      OP_MUL_SCALE: prod_q <= product;
      OP_DIV_INIT: begin
        quo_q <= prod_q[NUM_W-1:0];
        rem_q <= '0;
        cnt_q <= CW'(NUM_W - 1);
      end
      OP_DIV_STEP: begin
        rem_q <= rem_sub[SB-1:0];
        quo_q <= {quo_q[NUM_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_SAT:   result_q <= neg_q ? ({OUT_W{1'b0}} - q_sat) : q_sat;
      OP_CLEAR: result_q <= '0;
      OP_EMIT: begin
        if (!(out_valid_q && out_stall_i)) begin
          axis_value_q <= result_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.in_valid = in_valid_i;
  assign status_o.zero     = zero_q;
  assign status_o.div_more = (cnt_q != '0);
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign axis_value_o = $signed(axis_value_q);

  `JAC_ASSERT(a_rem_below_divisor, clk_i, rst_ni, (ctrl_i.op == OP_DIV_STEP) |-> (rem_q < range_q), "remainder reached divisor")
  `JAC_ASSERT(a_emit_loads_output, clk_i, rst_ni, ((ctrl_i.op == OP_EMIT) && !status_o.out_busy) |=> out_valid_q, "result not presented")

endmodule

// ===== design/joystick_axis_conditioner.sv =====
// Top level of the joystick axis conditioner: configuration registers and wiring.
// Instantiates jac_sequencer and jac_datapath; depends on jac_pkg.
//
// One raw converter sample in, one conditioned axis value out. A small control
// store sequences a shared multiplier and a one-bit-per-cycle divider: a sample
// whose result scales runs the restoring divide loop, while a sample inside the
// deadzone or with no active range skips the divide. The block takes one sample
// at a time and stalls its input while it works; the finished value sits in an
// output register, so a new sample is taken while the last one waits.
// Configuration writes belong between transactions, when the block is idle.
module joystick_axis_conditioner #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned FRACTION_BITS = 8,
  localparam int unsigned CFG_W = (SAMPLE_BITS > jac_pkg::DEADZONE_W) ?
                                  SAMPLE_BITS : jac_pkg::DEADZONE_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]                  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_BITS-1:0]            raw_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [jac_pkg::OUT_W-1:0]  axis_value_o
);
  import jac_pkg::*;

  logic [SAMPLE_BITS-1:0] axis_min_q, axis_center_q, axis_max_q;
  logic [DEADZONE_W-1:0]  deadzone_q;
  logic                   throttle_mode_q;
  logic [WEIGHT_W-1:0]    smoothing_weight_q;
  ctrl_t                  ctrl;
  status_t                status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_min_q         <= '0;
      axis_center_q      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      axis_max_q         <= '1;
      deadzone_q         <= RESET_DEADZONE;
      throttle_mode_q    <= 1'b0;
      smoothing_weight_q <= RESET_WEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AXIS_MIN:         axis_min_q         <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_AXIS_CENTER:      axis_center_q      <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_AXIS_MAX:         axis_max_q         <= cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_DEADZONE:         deadzone_q         <= cfg_wdata_i[DEADZONE_W-1:0];
        CFG_THROTTLE_MODE:    throttle_mode_q    <= cfg_wdata_i[0];
        CFG_SMOOTHING_WEIGHT: smoothing_weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a sample only at the waiting step of the program
  assign in_stall_o = (ctrl.op != OP_WAIT_IN);

  jac_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  jac_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .status_o           (status),
    .in_valid_i         (in_valid_i),
    .raw_sample_i       (raw_sample_i),
    .axis_min_i         (axis_min_q),
    .axis_center_i      (axis_center_q),
    .axis_max_i         (axis_max_q),
    .deadzone_i         (deadzone_q),
    .throttle_mode_i    (throttle_mode_q),
    .smoothing_weight_i (smoothing_weight_q),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .axis_value_o       (axis_value_o)
  );

endmodule

// ===== dv/joystick_axis_conditioner_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for joystick_axis_conditioner: each accepted sample is run
// through an in-bench predictor of smoothing, clamp, deadzone and scaling, then compared.
// Depends on jac_pkg and the joystick_axis_conditioner RTL.
module joystick_axis_conditioner_tb;
  import jac_pkg::*;

  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned CFG_W         = 12;
  localparam int unsigned LEVEL_W       = SAMPLE_W + FRAC_W;
  localparam int unsigned STUCK_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 45;
  localparam int unsigned BACKLOG_HOLD  = 400;
  localparam int unsigned ITEMS_PER_CAL = 58;
  localparam longint      FULL_NEG      = 32768;
  localparam longint      FULL_POS      = 32767;
  localparam longint      FULL_THR      = 255;
  localparam logic [SAMPLE_W-1:0]  RAW_TOP      = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = CFG_SMOOTHING_WEIGHT;

  logic                        clk_i;
  logic                        rst_ni       = 1'b0;
  logic                        cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i    = '0;
  logic [CFG_W-1:0]            cfg_wdata_i  = '0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [SAMPLE_W-1:0]         raw_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic signed [OUT_W-1:0]     axis_value_o;

  // predictor copy of the registers and the smoothing state
  logic [SAMPLE_W-1:0]   cal_min      = '0;
  logic [SAMPLE_W-1:0]   cal_center   = 12'd2048;
  logic [SAMPLE_W-1:0]   cal_max      = RAW_TOP;
  logic [DEADZONE_W-1:0] dz_half      = RESET_DEADZONE;
  logic                  throttle_on  = 1'b0;
  logic [WEIGHT_W-1:0]   ema_weight   = RESET_WEIGHT;
  logic [LEVEL_W-1:0]    level_q      = '0;
  logic                  level_seeded = 1'b0;

  logic signed [OUT_W-1:0] axis_expected_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned stuck_cycles;
  int unsigned samples_sent;
  int unsigned values_checked;
  int unsigned reg_writes;
  int unsigned fail_count;

  joystick_axis_conditioner #(
    .SAMPLE_BITS  (SAMPLE_W),
    .FRACTION_BITS(FRAC_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_sample_i(raw_sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .axis_value_o(axis_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the average by one sample and return the conditioned axis value.
  function automatic logic signed [OUT_W-1:0] predict_axis(input logic [SAMPLE_W-1:0] raw);
    longint w, acc, v, lo, c, hi, dz, diff, mag, span, q;
    w = (ema_weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(ema_weight);
    if (!level_seeded) begin
      level_q      = {(throttle_on ? cal_min : cal_center), {FRAC_W{1'b0}}};
      level_seeded = 1'b1;
    end
    acc = w * (longint'(raw) <<< FRAC_W) + (longint'(WEIGHT_ONE) - w) * longint'(level_q);
    level_q = LEVEL_W'(acc >>> WEIGHT_SHIFT);
    lo = longint'(cal_min);
    c  = longint'(cal_center);
    hi = longint'(cal_max);
    dz = longint'(dz_half);
    // min wins over max when the calibration is crossed
    v = longint'(level_q[LEVEL_W-1:FRAC_W]);
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    diff = v - c;
    q = 0;
    if (throttle_on) begin
      span = hi - c - dz;
      if (diff > dz && span > 0) begin
        q = (diff - dz) * FULL_THR / span;
        if (q > FULL_THR) q = FULL_THR;
      end
    end else begin
      mag = (diff < 0) ? -diff : diff;
      if (mag >= dz) begin
        if (v < c) begin
          span = c - lo - dz;
          if (span > 0) begin
            q = (mag - dz) * FULL_NEG / span;
            if (q > FULL_NEG) q = FULL_NEG;
            q = -q;
          end
        end else begin
          span = hi - c - dz;
          if (span > 0) begin
            q = (diff - dz) * FULL_POS / span;
            if (q > FULL_POS) q = FULL_POS;
          end
        end
      end
    end
    return OUT_W'(q);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_AXIS_MIN:         cal_min     = data[SAMPLE_W-1:0];
      CFG_AXIS_CENTER:      cal_center  = data[SAMPLE_W-1:0];
      CFG_AXIS_MAX:         cal_max     = data[SAMPLE_W-1:0];
      CFG_DEADZONE:         dz_half     = data[DEADZONE_W-1:0];
      CFG_THROTTLE_MODE:    throttle_on = data[0];
      CFG_SMOOTHING_WEIGHT: ema_weight  = data[WEIGHT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Drop valid, wait for every outstanding axis value, then let the sequencer go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (axis_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_calibration(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] c,
                                 input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] dz,
                                 input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] w);
    settle();
    write_reg(CFG_AXIS_MIN, lo);
    write_reg(CFG_AXIS_CENTER, c);
    write_reg(CFG_AXIS_MAX, hi);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_THROTTLE_MODE, thr);
    write_reg(CFG_SMOOTHING_WEIGHT, w);
  endtask

  // Offer one sample; return at the edge where the transaction completes.
  task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i   <= 1'b0;
      raw_sample_i <= SAMPLE_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    axis_expected_q.push_back(predict_axis(raw));
    samples_sent++;
  endtask

  // Hold the stick near one spot for a few samples, or throw noise.
  task automatic stick_burst();
    int unsigned len, pick;
    int          target, raw;
    pick = $urandom_range(5);
    len  = $urandom_range(12, 1);
    case (pick)
      0:       target = 0;
      1:       target = int'(RAW_TOP);
      2:       target = int'(cal_center) + int'($urandom_range(2 * dz_half + 2)) - int'(dz_half) - 1;
      default: target = int'($urandom_range(RAW_TOP));
    endcase
    repeat (len) begin
      if (pick == 5) raw = int'($urandom_range(RAW_TOP));
      else raw = target + int'($urandom_range(8)) - 4;
      if (raw < 0) raw = 0;
      if (raw > int'(RAW_TOP)) raw = int'(RAW_TOP);
      send_sample(SAMPLE_W'(raw));
    end
  endtask

  task automatic random_calibration();
    logic [CFG_W-1:0] lo, hi, c, w;
    if ($urandom_range(7) == 0) begin
      set_calibration(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                      CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    end else begin
      lo = CFG_W'($urandom_range(1500));
      hi = CFG_W'($urandom_range(4095, 2600));
      c  = CFG_W'($urandom_range(hi, lo));
      w  = ($urandom_range(5) == 0) ? CFG_W'($urandom_range(511, 256))
                                    : CFG_W'($urandom_range(256, 8));
      set_calibration(lo, c, hi, CFG_W'($urandom_range(300)), CFG_W'($urandom_range(1)), w);
    end
  endtask

  // First sample after reset seeds the average from axis_min in throttle mode.
  task automatic test_throttle_seeding();
    set_calibration(300, 2048, 3900, 50, 1, 51);
    send_sample(RAW_TOP);
    send_sample(RAW_TOP);
    send_sample(0);
    send_sample(2048);
  endtask

  // Full weight makes the average follow the raw sample exactly.
  task automatic test_deadzone_edges();
    set_calibration(0, 2048, RAW_TOP, 100, 0, 256);
    send_sample(2147);
    send_sample(2148);
    send_sample(2149);
    send_sample(1948);
    send_sample(1947);
    send_sample(0);
    send_sample(RAW_TOP);
    set_calibration(0, 2048, RAW_TOP, 100, 1, 256);
    send_sample(2148);
    send_sample(2149);
    send_sample(RAW_TOP);
    // upper data bit of the deadzone is dropped, leaving the widest deadzone
    set_calibration(0, 2048, RAW_TOP, 12'hFFF, 0, 256);
    send_sample(0);
    send_sample(RAW_TOP);
    set_calibration(0, 0, RAW_TOP, 0, 0, 256);
    send_sample(0);
    send_sample(RAW_TOP);
  endtask

  // Crossed calibration pushes the quotient past full scale; expect saturation.
  task automatic test_crossed_calibration();
    set_calibration(1000, 2000, 500, 0, 0, 256);
    send_sample(1500);
    set_calibration(3000, 1000, 2000, 0, 0, 256);
    send_sample(100);
    set_calibration(3000, 1000, 2000, 0, 1, 256);
    send_sample(100);
  endtask

  task automatic test_weight_extremes();
    set_calibration(0, 2048, RAW_TOP, 50, 0, 0);
    send_sample(RAW_TOP);
    send_sample(0);
    settle();
    write_reg(CFG_SMOOTHING_WEIGHT, 12'h1FF);
    send_sample(RAW_TOP);
    settle();
    // ignore writes to unused register slots
    for (int i = int'(CFG_IDX_LAST) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_W'($urandom));
    end
    send_sample(0);
    settle();
    write_reg(CFG_SMOOTHING_WEIGHT, 12'hE00);
    send_sample(RAW_TOP);
  endtask

  task automatic test_random_traffic();
    int unsigned phase_send[4] = '{0, 87, 0, 18};
    int unsigned phase_recv[4] = '{0, 0, 87, 18};
    int unsigned start;
    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (int s = 0; s < 4; s++) begin
        random_calibration();
        start = samples_sent;
        while (samples_sent - start < ITEMS_PER_CAL) stick_burst();
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_output_backlog();
    set_calibration(0, 2048, RAW_TOP, 50, 0, 128);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = BACKLOG_HOLD;
    repeat (6) send_sample(SAMPLE_W'($urandom));
  endtask

  // Result side: check each completed transaction, then drive the next stall value.
  initial begin : axis_checker
    logic signed [OUT_W-1:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (axis_expected_q.size() == 0) begin
          $error("axis_value: no value expected, actual %0d", axis_value_o);
          fail_count++;
        end else begin
          want = axis_expected_q.pop_front();
          if (axis_value_o !== want) begin
            $error("axis_value: expected %0d actual %0d", want, axis_value_o);
            fail_count++;
          end
        end
        values_checked++;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("joystick_axis_conditioner verification failed");
    $finish;
  end

  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_throttle_seeding();
    test_deadzone_edges();
    test_crossed_calibration();
    test_weight_extremes();
    test_random_traffic();
    test_output_backlog();
    settle();
    $display("Covered: %0d samples, %0d axis values checked, %0d register writes.",
             samples_sent, values_checked, reg_writes);
    $display("Modes: bipolar and throttle, deadzone and weight extremes, crossed calibration,");
    $display("random idle and stall phases, and a long output hold-off.");
    if (fail_count == 0) begin
      $display("joystick_axis_conditioner verification clean");
    end else begin
      $display("joystick_axis_conditioner verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/jac_pkg.sv
design/jac_sequencer.sv
design/jac_datapath.sv
design/joystick_axis_conditioner.sv
dv/joystick_axis_conditioner_tb.sv
